// ----- design/assert_macros.svh -----
// assertion helpers used by the queue design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while rst_n is low
`define QTSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define QTSL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/qtsl_pkg.sv -----
package qtsl_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [COUNT_W-1:0]        count_out_t;

endpackage

// ----- design/qtsl_if.sv -----
interface qtsl_in_if import qtsl_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  value_t value_in;

  modport source (output valid, output cmd, output value_in, input ready);
  modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

interface qtsl_out_if import qtsl_pkg::*; ();
  logic       valid;
  logic       ready;
  value_t     value_out;
  status_t    status;
  count_out_t count_after;

  modport source (output valid, output value_out, output status, output count_after,
                  input ready);
  modport sink   (input valid, input value_out, input status, input count_after,
                  output ready);
endinterface

// ----- design/qtsl_ram.sv -----
module qtsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/queue_two_stacks_lazy_transfer.sv -----
// channel  dir  payload                         request accepted when
// in_ch    in   cmd, value_in                   valid && ready
// out_ch   out  value_out, status, count_after  valid && ready
//
// an enqueue or an error is taken and its result registered in idle; a dequeue
// from a non-empty output stack also passes S_POP for the output stack memory read
// a dequeue that finds the output stack empty moves the input stack over,
// one element per cycle through the memory read, in S_XFER
// reset clears the control state and counters; both stack memories hold no reset value
// in_ch.ready is low while a dequeue is at work or a result waits unread
`include "assert_macros.svh"

module queue_two_stacks_lazy_transfer import qtsl_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst_n,
  qtsl_in_if.sink   in_ch,
  qtsl_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_XFER = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] in_depth_r, in_depth_nxt;
  logic [CW-1:0] out_depth_r, out_depth_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rd_pend_r, rd_pend_nxt;

  logic          out_valid_r, out_valid_nxt;
  value_t        value_r;
  status_t       status_r;
  count_out_t    count_out_r;

  logic          res_load;
  value_t        res_value;
  status_t       res_status;

  logic [CW-1:0] in_dec, out_dec;
  logic          in_we, out_we;
  logic [VALUE_W-1:0] in_rdata, out_rdata;
  logic [CW+COUNT_W-1:0] count_ext;

  logic          accept;

  assign in_dec = in_depth_r - 1'b1;
  assign out_dec = out_depth_r - 1'b1;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  qtsl_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_depth_r[AW-1:0]),
    .wdata (in_ch.value_in),
    .raddr (in_dec[AW-1:0]),
    .rdata (in_rdata)
  );

  qtsl_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_depth_r[AW-1:0]),
    .wdata (in_rdata),
    .raddr (out_dec[AW-1:0]),
    .rdata (out_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    in_depth_nxt  = in_depth_r;
    out_depth_nxt = out_depth_r;
    count_nxt     = count_r;
    rd_pend_nxt   = rd_pend_r;
    in_we         = 1'b0;
    out_we        = 1'b0;
    res_load      = 1'b0;
    res_value     = '0;
    res_status    = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_ENQ) begin
            res_load = 1'b1;
            if (count_r == CW'(CAPACITY)) begin
              res_status = ST_OVERFLOW;
            end else begin
              in_we        = 1'b1;
              in_depth_nxt = in_depth_r + 1'b1;
              count_nxt    = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            res_load   = 1'b1;
            res_status = ST_UNDERFLOW;
          end else if (out_depth_r != '0) begin
            // read address is the top of the output stack
            state_nxt = S_POP;
          end else begin
            state_nxt   = S_XFER;
            rd_pend_nxt = 1'b0;
          end
        end
      end
      S_POP: begin
        res_load      = 1'b1;
        res_value     = value_t'(out_rdata);
        out_depth_nxt = out_dec;
        count_nxt     = count_r - 1'b1;
        state_nxt     = S_IDLE;
      end
      S_XFER: begin
        if (rd_pend_r && (in_depth_r == '0)) begin
          // last element moved is the front: hand it out instead of storing it
          res_load    = 1'b1;
          res_value   = value_t'(in_rdata);
          count_nxt   = count_r - 1'b1;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          if (rd_pend_r) begin
            out_we        = 1'b1;
            out_depth_nxt = out_depth_r + 1'b1;
          end
          if (in_depth_r != '0) begin
            in_depth_nxt = in_dec;
            rd_pend_nxt  = 1'b1;
          end else begin
            rd_pend_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = res_load || (out_valid_r && !out_ch.ready);
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_depth_r  <= '0;
      out_depth_r <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_depth_r  <= in_depth_nxt;
      out_depth_r <= out_depth_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_r     <= res_value;
      status_r    <= res_status;
      count_out_r <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value_out   = value_r;
  assign out_ch.status      = status_r;
  assign out_ch.count_after = count_out_r;

  // one element in flight between the memories during a transfer
  `QTSL_ASSERT(a_count_sum,
    SW'(count_r) == SW'(in_depth_r) + SW'(out_depth_r) + SW'(rd_pend_r),
    "item count does not match the stack depths")
  `QTSL_NEVER(a_count_cap, count_r > CW'(CAPACITY), "item count above capacity")
  `QTSL_ASSERT(a_pop_result, state_r == S_POP |=> out_valid_r && status_r == ST_OK,
    "pop did not deliver a result")
  `QTSL_ASSERT(a_xfer_result,
    (state_r == S_XFER) && rd_pend_r && (in_depth_r == '0) |=> out_valid_r && state_r == S_IDLE,
    "transfer did not end with a result")

endmodule
